@@ hw/rtl/gars_pkg.sv @@
package gars_pkg;

    // Sizes
    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 65535;
    localparam int SCORE_BITS = 24;
    localparam int CFG_W      = 7;
    localparam int COL_AW     = $clog2(MAX_COLS);
    localparam int LEN_W      = $clog2(MAX_COLS + 1);
    localparam int ROW_W      = 16;
    localparam int SYM_W      = 8;
    localparam int OP_W       = 2;
    localparam int IDX_W      = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_ROW    = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MATCH    = 2'd0;
    localparam logic [IDX_W-1:0] REG_MISMATCH = 2'd1;
    localparam logic [IDX_W-1:0] REG_GAP      = 2'd2;

    // Register reset values
    localparam logic signed [CFG_W-1:0] MATCH_RST    = 7'sd1;
    localparam logic signed [CFG_W-1:0] MISMATCH_RST = -7'sd1;
    localparam logic signed [CFG_W-1:0] GAP_RST      = -7'sd1;

    // Saturation limits
    localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
    localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [SYM_W-1:0] symbol;
    } cmd_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]             row_index;
        logic [LEN_W-1:0]             col_index;
        logic signed [SCORE_BITS-1:0] cell_score;
        logic                         last;
    } cell_item_t;

    // Controller to datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic row_start;
        logic step;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic top_empty;
        logic last_col;
        logic out_busy;
    } sts_t;

    // Score plus a 7-bit signed term, clamped to the score range
    function automatic logic signed [SCORE_BITS-1:0] sat_add(
        input logic signed [SCORE_BITS-1:0] a,
        input logic signed [CFG_W-1:0]      b
    );
        logic signed [SCORE_BITS:0] sum;
        sum = {a[SCORE_BITS-1], a} + {{(SCORE_BITS + 1 - CFG_W){b[CFG_W-1]}}, b};
        if (sum[SCORE_BITS] != sum[SCORE_BITS-1])
        begin
            sat_add = sum[SCORE_BITS] ? SCORE_MIN : SCORE_MAX;
        end
        else
        begin
            sat_add = sum[SCORE_BITS-1:0];
        end
    endfunction

endpackage

@@ hw/rtl/global_alignment_row_scorer.sv @@
// Channel   Direction  Handshake                Payload
// cmd       in         cmd_valid / cmd_ready    cmd       (opcode, symbol)
// cell      out        cell_valid / cell_ready  cell_data (row_index, col_index, cell_score, last)
// cfg       in         cfg_we                   cfg_index, cfg_wdata
//
// Clear and append keep cmd_ready high. A row command first loads its symbol, then
// yields one cell per stored top symbol (up to 64) from the single score unit that
// walks the previous-row store one column a cycle while the cell output is not stalled.
// cmd_ready is low while a row is being computed; a stalled cell output holds the
// column walk in place. Reset (rst_n, asynchronous) restores the default scores
// and an empty alignment; the symbol and score stores are not cleared.
module global_alignment_row_scorer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  gars_pkg::cmd_item_t             cmd,
    output logic                            cell_valid,
    input  logic                            cell_ready,
    output gars_pkg::cell_item_t            cell_data,
    input  logic                            cfg_we,
    input  logic [gars_pkg::IDX_W-1:0]      cfg_index,
    input  logic [gars_pkg::CFG_W-1:0]      cfg_wdata
);

    gars_pkg::ctl_t ctl;
    gars_pkg::sts_t sts;

    gars_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .opcode     (cmd.opcode),
        .cell_ready (cell_ready),
        .sts        (sts),
        .ctl        (ctl)
    );

    gars_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbol     (cmd.symbol),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .ctl        (ctl),
        .sts        (sts),
        .cell_ready (cell_ready),
        .cell_valid (cell_valid),
        .cell_data  (cell_data)
    );

    // A non-final cell waiting means the row is still being walked
    a_busy_mid_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && !cell_data.last) |-> !cmd_ready)
        else $error("command taken while a row is unfinished");

    // Columns follow one another without gaps
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && cell_ready && !cell_data.last) |=>
            (cell_valid && (cell_data.col_index == $past(cell_data.col_index) + 1)))
        else $error("column sequence broken");

    // Column numbers stay within 1 to MAX_COLS
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid |-> (cell_data.col_index != 0)
                    && (cell_data.col_index <= gars_pkg::MAX_COLS))
        else $error("column index out of range");

endmodule

@@ hw/rtl/gars_ctrl.sv @@
module gars_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  logic [gars_pkg::OP_W-1:0] opcode,
    input  logic                  cell_ready,
    input  gars_pkg::sts_t        sts,
    output gars_pkg::ctl_t        ctl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   accept;
    logic   slot_free;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign slot_free = !sts.out_busy || cell_ready;

    // Decode and sequencing
    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        gars_pkg::OP_CLEAR:  ctl.clear  = 1'b1;
                        gars_pkg::OP_APPEND: ctl.append = 1'b1;
                        gars_pkg::OP_ROW:
                        begin
                            ctl.row_start = 1'b1;
                            if (!sts.top_empty)
                            begin
                                state_next = ST_CALC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_CALC:
            begin
                // one cell per cycle while the output slot can take it
                if (slot_free)
                begin
                    ctl.step = 1'b1;
                    if (sts.last_col)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/gars_dpath.sv @@
module gars_dpath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [gars_pkg::SYM_W-1:0]     symbol,
    input  logic                           cfg_we,
    input  logic [gars_pkg::IDX_W-1:0]     cfg_index,
    input  logic [gars_pkg::CFG_W-1:0]     cfg_wdata,
    input  gars_pkg::ctl_t                 ctl,
    output gars_pkg::sts_t                 sts,
    input  logic                           cell_ready,
    output logic                           cell_valid,
    output gars_pkg::cell_item_t           cell_data
);

    localparam int SW = gars_pkg::SCORE_BITS;

    // Score registers
    logic signed [gars_pkg::CFG_W-1:0] match_reg, mismatch_reg, gap_reg;

    // Alignment state
    logic [gars_pkg::LEN_W-1:0]  top_len_reg, top_len_next;
    logic [gars_pkg::ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic signed [SW-1:0]        left_bdr_reg, left_bdr_next;
    logic signed [SW-1:0]        top_bdr_reg, top_bdr_next;
    logic [gars_pkg::COL_AW-1:0] col_reg, col_next;
    logic signed [SW-1:0]        diag_reg, diag_next;
    logic signed [SW-1:0]        left_reg, left_next;
    logic [gars_pkg::SYM_W-1:0]  sym_reg, sym_next;

    // Stores
    logic [gars_pkg::SYM_W-1:0]  seq_mem  [gars_pkg::MAX_COLS];
    logic signed [SW-1:0]        prev_mem [gars_pkg::MAX_COLS];
    logic [gars_pkg::SYM_W-1:0]  seq_rd_reg;
    logic signed [SW-1:0]        prev_rd_reg;
    logic [gars_pkg::COL_AW-1:0] rd_addr;
    logic [gars_pkg::COL_AW-1:0] prev_waddr;
    logic signed [SW-1:0]        prev_wdata;
    logic                        prev_we;

    // Output register
    logic                  cell_valid_reg;
    gars_pkg::cell_item_t  cell_reg;

    // Cell arithmetic
    logic                              append_ok;
    logic                              last_col;
    logic signed [gars_pkg::CFG_W-1:0] diag_term;
    logic signed [SW-1:0]              cand_a, cand_b, cand_c, best;
    logic [gars_pkg::LEN_W-1:0]        col_num;

    assign append_ok = (row_cnt_reg == '0)
                    && (top_len_reg < gars_pkg::LEN_W'(gars_pkg::MAX_COLS));
    assign col_num   = gars_pkg::LEN_W'(col_reg) + gars_pkg::LEN_W'(1);
    assign last_col  = (col_num == top_len_reg);

    assign diag_term = (seq_rd_reg == sym_reg) ? match_reg : mismatch_reg;
    assign cand_a    = gars_pkg::sat_add(diag_reg, diag_term);
    assign cand_b    = gars_pkg::sat_add(prev_rd_reg, gap_reg);
    assign cand_c    = gars_pkg::sat_add(left_reg, gap_reg);

    // Best of the three candidates
    always_comb
    begin
        best = cand_a;
        if (cand_b > best)
        begin
            best = cand_b;
        end
        if (cand_c > best)
        begin
            best = cand_c;
        end
    end

    // Next state of the alignment registers
    always_comb
    begin
        top_len_next  = top_len_reg;
        row_cnt_next  = row_cnt_reg;
        left_bdr_next = left_bdr_reg;
        top_bdr_next  = top_bdr_reg;
        col_next      = col_reg;
        diag_next     = diag_reg;
        left_next     = left_reg;
        sym_next      = sym_reg;
        if (ctl.clear)
        begin
            top_len_next  = '0;
            row_cnt_next  = '0;
            left_bdr_next = '0;
            top_bdr_next  = '0;
            col_next      = '0;
        end
        if (ctl.append && append_ok)
        begin
            top_bdr_next = gars_pkg::sat_add(top_bdr_reg, gap_reg);
            top_len_next = top_len_reg + gars_pkg::LEN_W'(1);
        end
        if (ctl.row_start)
        begin
            if (row_cnt_reg < gars_pkg::ROW_W'(gars_pkg::MAX_ROWS))
            begin
                row_cnt_next = row_cnt_reg + gars_pkg::ROW_W'(1);
            end
            left_bdr_next = gars_pkg::sat_add(left_bdr_reg, gap_reg);
            diag_next     = left_bdr_reg;
            left_next     = left_bdr_next;
            sym_next      = symbol;
        end
        if (ctl.step)
        begin
            diag_next = prev_rd_reg;
            left_next = best;
            col_next  = last_col ? '0 : col_reg + gars_pkg::COL_AW'(1);
        end
    end

    // Column counter rests at zero between rows, so column 0 is already read
    assign rd_addr = col_next;

    // Previous-row store written by appends (top border) and by cells
    assign prev_we    = (ctl.append && append_ok) || ctl.step;
    assign prev_waddr = ctl.step ? col_reg : top_len_reg[gars_pkg::COL_AW-1:0];
    assign prev_wdata = ctl.step ? best : top_bdr_next;

    always_ff @(posedge clk)
    begin
        if (ctl.append && append_ok)
        begin
            seq_mem[top_len_reg[gars_pkg::COL_AW-1:0]] <= symbol;
        end
        seq_rd_reg <= seq_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        prev_rd_reg <= prev_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_len_reg    <= '0;
            row_cnt_reg    <= '0;
            left_bdr_reg   <= '0;
            top_bdr_reg    <= '0;
            col_reg        <= '0;
            cell_valid_reg <= 1'b0;
            match_reg      <= gars_pkg::MATCH_RST;
            mismatch_reg   <= gars_pkg::MISMATCH_RST;
            gap_reg        <= gars_pkg::GAP_RST;
        end
        else
        begin
            top_len_reg  <= top_len_next;
            row_cnt_reg  <= row_cnt_next;
            left_bdr_reg <= left_bdr_next;
            top_bdr_reg  <= top_bdr_next;
            col_reg      <= col_next;
            if (ctl.step)
            begin
                cell_valid_reg <= 1'b1;
            end
            else if (cell_ready)
            begin
                cell_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gars_pkg::REG_MATCH:    match_reg    <= cfg_wdata;
                    gars_pkg::REG_MISMATCH: mismatch_reg <= cfg_wdata;
                    gars_pkg::REG_GAP:      gap_reg      <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Row working registers and output payload
    always_ff @(posedge clk)
    begin
        diag_reg <= diag_next;
        left_reg <= left_next;
        sym_reg  <= sym_next;
        if (ctl.step)
        begin
            cell_reg.row_index  <= row_cnt_reg;
            cell_reg.col_index  <= col_num;
            cell_reg.cell_score <= best;
            cell_reg.last       <= last_col;
        end
    end

    assign sts.top_empty = (top_len_reg == '0);
    assign sts.last_col  = last_col;
    assign sts.out_busy  = cell_valid_reg;
    assign cell_valid    = cell_valid_reg;
    assign cell_data     = cell_reg;

endmodule
